/* rtl/bcd12_pkg.sv */
`default_nettype none

package bcd12_pkg;

    // command codes of the input channel
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // segment patterns
    localparam logic [7:0] SEG_DASH  = 8'h40;
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_DOT   = 8'h80;

    localparam logic [7:0] SEG_TABLE [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // time of day as 8-bit digit counters plus am/pm flag
    typedef struct packed {
        logic [7:0] sec_ones;
        logic [7:0] sec_tens;
        logic [7:0] min_ones;
        logic [7:0] min_tens;
        logic [7:0] hour_ones;
        logic [7:0] hour_tens;
        logic       pm;
    } bcd12_time_t;

    // 12:00:00 am
    localparam bcd12_time_t TIME_RESET = '{
        sec_ones:  8'd0,
        sec_tens:  8'd0,
        min_ones:  8'd0,
        min_tens:  8'd0,
        hour_ones: 8'd2,
        hour_tens: 8'd1,
        pm:        1'b0
    };

    typedef struct packed {
        logic [7:0] digit_one;
        logic [7:0] digit_two;
        logic [7:0] digit_three;
        logic [7:0] digit_four;
    } bcd12_segs_t;

    localparam bcd12_segs_t SEGS_RESET = '{
        digit_one:   SEG_DASH,
        digit_two:   SEG_DASH,
        digit_three: SEG_DASH,
        digit_four:  SEG_DASH
    };

endpackage

`default_nettype wire

/* rtl/bcd12_advance.sv */
`default_nettype none

module bcd12_advance import bcd12_pkg::*; (
    input  bcd12_time_t time_cur,
    output bcd12_time_t time_adv
);

    logic [7:0] so_inc;
    logic [7:0] st_inc;
    logic [7:0] mo_inc;
    logic [7:0] mt_inc;
    logic [7:0] ho_inc;
    logic [7:0] ht_inc;

    assign so_inc = time_cur.sec_ones  + 8'd1;
    assign st_inc = time_cur.sec_tens  + 8'd1;
    assign mo_inc = time_cur.min_ones  + 8'd1;
    assign mt_inc = time_cur.min_tens  + 8'd1;
    assign ho_inc = time_cur.hour_ones + 8'd1;
    assign ht_inc = time_cur.hour_tens + 8'd1;

    // one-second step with cascading roll-overs, digits wrap at 8 bits
    always_comb begin
        time_adv = time_cur;
        time_adv.sec_ones = so_inc;
        if (so_inc == 8'd10) begin
            time_adv.sec_ones = 8'd0;
            time_adv.sec_tens = st_inc;
            if (st_inc == 8'd6) begin
                time_adv.sec_tens = 8'd0;
                time_adv.min_ones = mo_inc;
                if (mo_inc == 8'd10) begin
                    time_adv.min_ones = 8'd0;
                    time_adv.min_tens = mt_inc;
                    if (mt_inc == 8'd6) begin
                        time_adv.min_tens  = 8'd0;
                        time_adv.hour_ones = ho_inc;
                        // hour roll-over: 9 to 10, 12 to 1, am/pm flips at 12
                        if (time_cur.hour_tens == 8'd0 && ho_inc == 8'd10) begin
                            time_adv.hour_ones = 8'd0;
                            time_adv.hour_tens = ht_inc;
                        end else if (time_cur.hour_tens == 8'd1 && ho_inc == 8'd3) begin
                            time_adv.hour_ones = 8'd1;
                            time_adv.hour_tens = 8'd0;
                        end else if (time_cur.hour_tens == 8'd1 && ho_inc == 8'd2) begin
                            time_adv.pm = ~time_cur.pm;
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/bcd12_segments.sv */
`default_nettype none

module bcd12_segments import bcd12_pkg::*; (
    input  bcd12_time_t time_cur,
    input  logic        blink,
    output bcd12_segs_t segs
);

    // digit to pattern, out-of-range digits blank
    function automatic logic [7:0] seg_of(input logic [7:0] d);
        logic [7:0] pat;
        pat = SEG_BLANK;
        if (d <= 8'd9) begin
            pat = SEG_TABLE[d[3:0]];
        end
        return pat;
    endfunction

    // leading hours zero blanked, pm dot on digit one, colon dots blink
    always_comb begin
        segs.digit_one   = (time_cur.hour_tens != 8'd0) ? seg_of(time_cur.hour_tens)
                                                        : SEG_BLANK;
        segs.digit_two   = seg_of(time_cur.hour_ones);
        segs.digit_three = seg_of(time_cur.min_tens);
        segs.digit_four  = seg_of(time_cur.min_ones);
        if (time_cur.pm) begin
            segs.digit_one = segs.digit_one | SEG_DOT;
        end
        if (blink) begin
            segs.digit_two  = segs.digit_two | SEG_DOT;
            segs.digit_four = segs.digit_four | SEG_DOT;
        end
    end

endmodule

`default_nettype wire

/* rtl/bcd_twelve_hour_clock_display_core.sv */
`default_nettype none

// channel   direction  ports
// --------  ---------  ---------------------------------------------------------------
// s_        input      s_valid s_ready s_cmd s_hours_byte s_minutes_byte s_seconds_byte
//                      s_check_byte
// m_        result     m_valid m_ready m_seg_digit_one..four m_running m_set_accepted
//
// Each item goes from the input register through the time and segment logic into the
// result register.
// A new item is taken every cycle while m_ready does not stall the result side; the time
// registers are updated once per item and feed the next item directly.
// Synchronous active-low reset gives 12:00:00 am, clock stopped, dashes on display.
// A stall on m_ready holds both stages; s_ready falls only when both are full.

module bcd_twelve_hour_clock_display_core import bcd12_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_cmd,
    input  wire logic [7:0] s_hours_byte,
    input  wire logic [7:0] s_minutes_byte,
    input  wire logic [7:0] s_seconds_byte,
    input  wire logic [7:0] s_check_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_seg_digit_one,
    output logic [7:0]      m_seg_digit_two,
    output logic [7:0]      m_seg_digit_three,
    output logic [7:0]      m_seg_digit_four,
    output logic            m_running,
    output logic            m_set_accepted
);

    // input stage
    logic       in_valid_reg;
    logic       cmd_reg;
    logic [7:0] hours_reg;
    logic [7:0] minutes_reg;
    logic [7:0] seconds_reg;
    logic [7:0] check_reg;

    // clock state
    bcd12_time_t time_reg;
    bcd12_time_t time_next;
    logic [1:0]  quarter_reg;
    logic [1:0]  quarter_next;
    logic        running_reg;
    logic        running_next;
    bcd12_segs_t segs_reg;
    bcd12_segs_t segs_next;

    // result stage
    logic        out_valid_reg;
    bcd12_segs_t out_segs_reg;
    logic        out_running_reg;
    logic        out_accepted_reg;
    logic        accepted_next;

    logic        advance;
    logic        do_item;
    bcd12_time_t time_adv;
    bcd12_time_t time_ticked;
    bcd12_segs_t segs_built;
    logic [9:0]  byte_sum;

    assign advance = !out_valid_reg || m_ready;
    assign do_item = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    bcd12_advance u_advance (
        .time_cur (time_reg),
        .time_adv (time_adv)
    );

    assign time_ticked = (running_reg && quarter_next == 2'd3) ? time_adv : time_reg;

    bcd12_segments u_segments (
        .time_cur (time_ticked),
        .blink    (quarter_next[1]),
        .segs     (segs_built)
    );

    assign quarter_next = quarter_reg + 2'd1;
    assign byte_sum = {2'b00, hours_reg} + {2'b00, minutes_reg} + {2'b00, seconds_reg};

    // per-item state update
    always_comb begin
        time_next     = time_reg;
        running_next  = running_reg;
        segs_next     = segs_reg;
        accepted_next = 1'b0;
        case (cmd_reg)
            CMD_TICK: begin
                if (running_reg) begin
                    time_next = time_ticked;
                    segs_next = segs_built;
                end
            end
            default: begin
                if (byte_sum == {2'b00, check_reg}) begin
                    time_next.pm        = hours_reg[7];
                    time_next.hour_tens = {6'd0, hours_reg[5:4]};
                    time_next.hour_ones = {4'd0, hours_reg[3:0]};
                    time_next.min_tens  = {5'd0, minutes_reg[6:4]};
                    time_next.min_ones  = {4'd0, minutes_reg[3:0]};
                    time_next.sec_tens  = {5'd0, seconds_reg[6:4]};
                    time_next.sec_ones  = {4'd0, seconds_reg[3:0]};
                    running_next        = 1'b1;
                    accepted_next       = 1'b1;
                end
            end
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg     <= s_cmd;
            hours_reg   <= s_hours_byte;
            minutes_reg <= s_minutes_byte;
            seconds_reg <= s_seconds_byte;
            check_reg   <= s_check_byte;
        end
    end

    // clock state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg    <= TIME_RESET;
            quarter_reg <= 2'd0;
            running_reg <= 1'b0;
            segs_reg    <= SEGS_RESET;
        end else if (do_item) begin
            time_reg    <= time_next;
            running_reg <= running_next;
            segs_reg    <= segs_next;
            if (cmd_reg == CMD_TICK) begin
                quarter_reg <= quarter_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (do_item) begin
            out_segs_reg     <= segs_next;
            out_running_reg  <= running_next;
            out_accepted_reg <= accepted_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_seg_digit_one   = out_segs_reg.digit_one;
    assign m_seg_digit_two   = out_segs_reg.digit_two;
    assign m_seg_digit_three = out_segs_reg.digit_three;
    assign m_seg_digit_four  = out_segs_reg.digit_four;
    assign m_running         = out_running_reg;
    assign m_set_accepted    = out_accepted_reg;

    // an accepted set always reports a running clock
    a_accept_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_set_accepted |-> m_running)
        else $error("set accepted without running clock");

    // once started the clock never stops
    a_running_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |=> running_reg)
        else $error("running flag cleared");

    // quarter counter moves only on a processed tick
    a_quarter_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(do_item && cmd_reg == CMD_TICK) |=> $stable(quarter_reg))
        else $error("quarter counter moved without tick");

    // the result register follows the display state after each item
    a_result_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        do_item |=> m_valid && out_segs_reg == segs_reg)
        else $error("result segments differ from display state");

endmodule

`default_nettype wire

/* test/tb_bcd_twelve_hour_clock_display_core.sv */
`timescale 1ns / 1ps

module tb_bcd_twelve_hour_clock_display_core;
    import bcd12_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DIRECTED_COUNT  = 25;
    localparam int RANDOM_ITEMS    = 625;
    localparam int AM_ROLL_TICKS   = 200;
    localparam int DRAIN_CYCLES    = 10;
    localparam int IDLE_PERCENT    = 13;
    localparam int CALM_FIRST      = 300;
    localparam int CALM_LAST       = 450;

    typedef struct packed {
        logic [7:0] digit_one;
        logic [7:0] digit_two;
        logic [7:0] digit_three;
        logic [7:0] digit_four;
        logic       running;
        logic       set_accepted;
    } display_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic [7:0] checksum;
        logic       fixed;
        display_t   result;
    } stim_row_t;

    localparam display_t DASHES_STOPPED = {SEG_DASH, SEG_DASH, SEG_DASH, SEG_DASH, 1'b0, 1'b0};
    localparam display_t DASHES_LOADED  = {SEG_DASH, SEG_DASH, SEG_DASH, SEG_DASH, 1'b1, 1'b1};
    localparam display_t FROM_PREDICTOR = '0;

    logic       aclk;
    logic       aresetn           = 1'b0;
    logic       s_valid           = 1'b0;
    logic       s_ready;
    logic       s_cmd             = CMD_TICK;
    logic [7:0] s_hours_byte      = 8'h00;
    logic [7:0] s_minutes_byte    = 8'h00;
    logic [7:0] s_seconds_byte    = 8'h00;
    logic [7:0] s_check_byte      = 8'h00;
    logic       m_valid;
    logic       m_ready           = 1'b0;
    logic [7:0] m_seg_digit_one;
    logic [7:0] m_seg_digit_two;
    logic [7:0] m_seg_digit_three;
    logic [7:0] m_seg_digit_four;
    logic       m_running;
    logic       m_set_accepted;

    // predicted clock state
    logic [1:0] tick_phase;
    logic       clock_on;
    logic [7:0] secs_lo, secs_hi, mins_lo, mins_hi, hrs_lo, hrs_hi;
    logic       afternoon;
    display_t   panel;

    display_t   pending_displays [$];
    display_t   seen_display;
    stim_row_t  directed_rows [DIRECTED_COUNT];
    logic       idle_on = 1'b1;
    int         mismatch_count = 0;
    int         results_seen = 0;
    int         quiet_cycles = 0;

    bcd_twelve_hour_clock_display_core u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_hours_byte      (s_hours_byte),
        .s_minutes_byte    (s_minutes_byte),
        .s_seconds_byte    (s_seconds_byte),
        .s_check_byte      (s_check_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_seg_digit_one   (m_seg_digit_one),
        .m_seg_digit_two   (m_seg_digit_two),
        .m_seg_digit_three (m_seg_digit_three),
        .m_seg_digit_four  (m_seg_digit_four),
        .m_running         (m_running),
        .m_set_accepted    (m_set_accepted)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // seven-segment pattern of one digit, blank when out of range
    function automatic logic [7:0] digit_segments(input logic [7:0] digit);
        case (digit)
            8'd0: digit_segments = 8'h3F;
            8'd1: digit_segments = 8'h06;
            8'd2: digit_segments = 8'h5B;
            8'd3: digit_segments = 8'h4F;
            8'd4: digit_segments = 8'h66;
            8'd5: digit_segments = 8'h6D;
            8'd6: digit_segments = 8'h7D;
            8'd7: digit_segments = 8'h07;
            8'd8: digit_segments = 8'h7F;
            8'd9: digit_segments = 8'h6F;
            default: digit_segments = SEG_BLANK;
        endcase
    endfunction

    // advance the predicted clock by one item and return the display it leaves
    function automatic display_t predict_clock_step(input logic cmd, input logic [7:0] hours,
            input logic [7:0] minutes, input logic [7:0] seconds, input logic [7:0] checksum);
        display_t   res;
        logic [9:0] byte_sum;
        logic       roll;
        res = '0;
        byte_sum = {2'b00, hours} + {2'b00, minutes} + {2'b00, seconds};
        if (cmd == CMD_TICK) begin
            tick_phase = tick_phase + 2'd1;
            if (clock_on) begin
                if (tick_phase == 2'd3) begin
                    // one second, carrying only out of a digit that just rolled
                    secs_lo = secs_lo + 8'd1;
                    roll = (secs_lo == 8'd10);
                    if (roll) begin
                        secs_lo = 8'd0;
                        secs_hi = secs_hi + 8'd1;
                        roll = (secs_hi == 8'd6);
                    end
                    if (roll) begin
                        secs_hi = 8'd0;
                        mins_lo = mins_lo + 8'd1;
                        roll = (mins_lo == 8'd10);
                    end
                    if (roll) begin
                        mins_lo = 8'd0;
                        mins_hi = mins_hi + 8'd1;
                        roll = (mins_hi == 8'd6);
                    end
                    if (roll) begin
                        mins_hi = 8'd0;
                        hrs_lo = hrs_lo + 8'd1;
                        if (hrs_hi == 8'd0 && hrs_lo == 8'd10) begin
                            hrs_lo = 8'd0;
                            hrs_hi = hrs_hi + 8'd1;
                        end else if (hrs_hi == 8'd1 && hrs_lo == 8'd3) begin
                            hrs_lo = 8'd1;
                            hrs_hi = 8'd0;
                        end else if (hrs_hi == 8'd1 && hrs_lo == 8'd2) begin
                            afternoon = !afternoon;
                        end
                    end
                end
                // redraw, leading hours zero blanked, colon follows the half second
                panel.digit_one   = (hrs_hi != 8'd0) ? digit_segments(hrs_hi) : SEG_BLANK;
                panel.digit_two   = digit_segments(hrs_lo);
                panel.digit_three = digit_segments(mins_hi);
                panel.digit_four  = digit_segments(mins_lo);
                if (afternoon) begin
                    panel.digit_one = panel.digit_one | SEG_DOT;
                end
                if (tick_phase[1]) begin
                    panel.digit_two  = panel.digit_two | SEG_DOT;
                    panel.digit_four = panel.digit_four | SEG_DOT;
                end
            end
        end else if ({2'b00, checksum} == byte_sum) begin
            afternoon = hours[7];
            hrs_hi    = {6'd0, hours[5:4]};
            hrs_lo    = {4'd0, hours[3:0]};
            mins_hi   = {5'd0, minutes[6:4]};
            mins_lo   = {4'd0, minutes[3:0]};
            secs_hi   = {5'd0, seconds[6:4]};
            secs_lo   = {4'd0, seconds[3:0]};
            clock_on  = 1'b1;
            res.set_accepted = 1'b1;
        end
        res.digit_one   = panel.digit_one;
        res.digit_two   = panel.digit_two;
        res.digit_three = panel.digit_three;
        res.digit_four  = panel.digit_four;
        res.running     = clock_on;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
            input logic [7:0] want);
        $display("mismatch on %s at result %0d: got %02h, expected %02h",
                 what, results_seen, got, want);
        mismatch_count++;
    endtask

    task automatic check_display(input display_t got, input display_t want);
        if (got.digit_one !== want.digit_one)
            report_mismatch("seg_digit_one", got.digit_one, want.digit_one);
        if (got.digit_two !== want.digit_two)
            report_mismatch("seg_digit_two", got.digit_two, want.digit_two);
        if (got.digit_three !== want.digit_three)
            report_mismatch("seg_digit_three", got.digit_three, want.digit_three);
        if (got.digit_four !== want.digit_four)
            report_mismatch("seg_digit_four", got.digit_four, want.digit_four);
        if (got.running !== want.running)
            report_mismatch("running", {7'd0, got.running}, {7'd0, want.running});
        if (got.set_accepted !== want.set_accepted)
            report_mismatch("set_accepted", {7'd0, got.set_accepted},
                            {7'd0, want.set_accepted});
    endtask

    // one input transfer, optional gap first, then log the expected display
    task automatic transfer_item(input logic cmd, input logic [7:0] hours, minutes, seconds,
            checksum, input logic use_fixed, input display_t fixed_result);
        display_t predicted;
        if (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_hours_byte   <= hours;
        s_minutes_byte <= minutes;
        s_seconds_byte <= seconds;
        s_check_byte   <= checksum;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_clock_step(cmd, hours, minutes, seconds, checksum);
        pending_displays.push_back(use_fixed ? fixed_result : predicted);
    endtask

    // mostly ticks; sets are usually well formed and close to a roll-over
    task automatic send_random_item();
        logic [31:0] noise;
        logic [31:0] pick_val;
        logic [9:0]  byte_sum;
        logic [7:0]  hours, minutes, seconds, checksum;
        int          pick;
        noise    = $urandom;
        hours    = noise[7:0];
        minutes  = noise[15:8];
        seconds  = noise[23:16];
        checksum = noise[31:24];
        pick     = $urandom_range(0, 99);
        if (pick < 65) begin
            transfer_item(CMD_TICK, hours, minutes, seconds, checksum, 1'b0, FROM_PREDICTOR);
        end else begin
            if (pick < 95) begin
                hours[7] = ($urandom_range(0, 3) == 0);
                hours[6] = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 3) != 0) begin
                    pick_val = $urandom_range(1, 12);
                    if (pick_val >= 10) pick_val = pick_val + 6;
                    hours[5:0] = pick_val[5:0];
                end
                minutes[7] = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 1) == 0) begin
                    minutes[6:0] = 7'h59;
                end else if ($urandom_range(0, 7) != 0) begin
                    pick_val = $urandom_range(0, 5);
                    minutes[6:4] = pick_val[2:0];
                    pick_val = $urandom_range(0, 9);
                    minutes[3:0] = pick_val[3:0];
                end
                seconds[7] = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 1) == 0) begin
                    pick_val = $urandom_range(5, 9);
                    seconds[6:0] = {3'd5, pick_val[3:0]};
                end else if ($urandom_range(0, 7) != 0) begin
                    pick_val = $urandom_range(0, 5);
                    seconds[6:4] = pick_val[2:0];
                    pick_val = $urandom_range(0, 9);
                    seconds[3:0] = pick_val[3:0];
                end
            end
            byte_sum = {2'b00, hours} + {2'b00, minutes} + {2'b00, seconds};
            if (pick < 88) begin
                checksum = byte_sum[7:0];
            end else if (pick < 95) begin
                // corrupted checksum
                pick_val = $urandom_range(1, 255);
                checksum = byte_sum[7:0] ^ pick_val[7:0];
            end else if ($urandom_range(0, 1) == 0) begin
                checksum = byte_sum[7:0];
            end
            transfer_item(CMD_SET, hours, minutes, seconds, checksum, 1'b0, FROM_PREDICTOR);
        end
    endtask

    // result side stalls at random except in the calm stretch
    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // compare each result transfer with the oldest expected display
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_display = {m_seg_digit_one, m_seg_digit_two, m_seg_digit_three,
                            m_seg_digit_four, m_running, m_set_accepted};
            if (pending_displays.size() == 0)
                report_mismatch("result with none pending", 8'd1, 8'd0);
            else
                check_display(seen_display, pending_displays.pop_front());
            results_seen++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_bcd_twelve_hour_clock_display_core: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] noise;

        // tick payloads are don't-care; time sets cover every roll-over path
        directed_rows = '{
            // tick while stopped leaves dashes
            {CMD_TICK, 8'hA5, 8'h5A, 8'hFF, 8'h00, 1'b1, DASHES_STOPPED},
            // checksum overflow, sum above 255
            {CMD_SET,  8'hFF, 8'hFF, 8'hFF, 8'hFD, 1'b1, DASHES_STOPPED},
            // plain bad checksum
            {CMD_SET,  8'h12, 8'h00, 8'h00, 8'h13, 1'b1, DASHES_STOPPED},
            // 11:59:59 am, display not redrawn until a tick
            {CMD_SET,  8'h11, 8'h59, 8'h59, 8'hC3, 1'b1, DASHES_LOADED},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            // 12:59:59 rolls to 1 with blanked leading zero
            {CMD_SET,  8'h12, 8'h59, 8'h59, 8'hC4, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            // 9:59:59 rolls to 10
            {CMD_SET,  8'h09, 8'h59, 8'h59, 8'hBB, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            // field extremes, out-of-range digits show blank
            {CMD_SET,  8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            {CMD_SET,  8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            {CMD_SET,  8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            // all zero is a valid set
            {CMD_SET,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            {CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, FROM_PREDICTOR},
            {CMD_SET,  8'h00, 8'h00, 8'h00, 8'h01, 1'b0, FROM_PREDICTOR}
        };

        // predicted state after reset: 12:00:00 am, stopped, dashes
        tick_phase = 2'd0;
        clock_on   = 1'b0;
        secs_lo    = 8'd0;
        secs_hi    = 8'd0;
        mins_lo    = 8'd0;
        mins_hi    = 8'd0;
        hrs_lo     = 8'd2;
        hrs_hi     = 8'd1;
        afternoon  = 1'b0;
        panel      = DASHES_STOPPED;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int row = 0; row < DIRECTED_COUNT; row++) begin
            transfer_item(directed_rows[row].cmd, directed_rows[row].hours,
                          directed_rows[row].minutes, directed_rows[row].seconds,
                          directed_rows[row].checksum, directed_rows[row].fixed,
                          directed_rows[row].result);
        end

        // hold the sender until every directed result is back
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_displays.size() != 0) @(posedge aclk);

        // 11:59:15 pm with the largest checksum that still matches, runs on to 12 am
        transfer_item(CMD_SET, 8'h91, 8'h59, 8'h15, 8'hFF, 1'b0, FROM_PREDICTOR);
        for (int n = 0; n < AM_ROLL_TICKS; n++) begin
            noise = $urandom;
            transfer_item(CMD_TICK, noise[7:0], noise[15:8], noise[23:16], noise[31:24],
                          1'b0, FROM_PREDICTOR);
        end

        // random traffic with a stretch of no stalls on either side
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= CALM_FIRST && n < CALM_LAST);
            send_random_item();
        end
        idle_on = 1'b1;

        s_valid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb_bcd_twelve_hour_clock_display_core: PASS");
        end else begin
            $display("tb_bcd_twelve_hour_clock_display_core: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bcd12_pkg.sv
rtl/bcd12_advance.sv
rtl/bcd12_segments.sv
rtl/bcd_twelve_hour_clock_display_core.sv
test/tb_bcd_twelve_hour_clock_display_core.sv
